@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/hkr_pkg.sv @@
// Hotkey router package: codes, widths, shared types and helper functions.
// No dependencies.
package hkr_pkg;

	localparam int KEY_W        = 8;
	localparam int MOD_W        = 4;
	localparam int BIND_W       = KEY_W + MOD_W;
	localparam int NUM_BIND     = 5;
	localparam int BIND_IDX_W   = 3;
	localparam int KEY_SPACE_DEF = 256;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;

	// commands
	localparam logic [1:0] CMD_KEY    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// actions
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_TALK_PRESS = 3'd1;
	localparam logic [2:0] ACT_TALK_REL  = 3'd2;
	localparam logic [2:0] ACT_TOGGLE    = 3'd3;
	localparam logic [2:0] ACT_TRANSLATE = 3'd4;
	localparam logic [2:0] ACT_UNDO      = 3'd5;
	localparam logic [2:0] ACT_CANCEL    = 3'd6;

	// binding register indexes, also the match priority order
	localparam logic [BIND_IDX_W-1:0] REG_TALK      = 3'd0;
	localparam logic [BIND_IDX_W-1:0] REG_TOGGLE    = 3'd1;
	localparam logic [BIND_IDX_W-1:0] REG_TRANSLATE = 3'd2;
	localparam logic [BIND_IDX_W-1:0] REG_UNDO      = 3'd3;
	localparam logic [BIND_IDX_W-1:0] REG_CANCEL    = 3'd4;

	typedef logic [NUM_BIND-1:0][BIND_W-1:0] bind_arr_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
		logic             down;
		logic             rpt;
		logic [MOD_W-1:0] mods;
		logic             companion;
	} event_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [KEY_W-1:0] key;
		logic             suppress;
	} result_t;

	// state update request from the decision logic to the key map
	typedef struct packed {
		logic set_bit;
		logic clr_bit;
		logic clr_all;
		logic hold_set;
		logic hold_drop;
	} map_op_t;

	function automatic logic [2:0] bind_action(input logic [BIND_IDX_W-1:0] idx);
		logic [2:0] act;
		unique case (idx)
			REG_TALK:      act = ACT_TALK_PRESS;
			REG_TOGGLE:    act = ACT_TOGGLE;
			REG_TRANSLATE: act = ACT_TRANSLATE;
			REG_UNDO:      act = ACT_UNDO;
			REG_CANCEL:    act = ACT_CANCEL;
			default:       act = ACT_NONE;
		endcase
		return act;
	endfunction

	function automatic logic needs_companion(input logic [BIND_IDX_W-1:0] idx);
		return (idx == REG_UNDO) || (idx == REG_CANCEL);
	endfunction

endpackage

@@ design/hkr_decide.sv @@
// Hotkey decision logic: binding match, release and repeat handling.
// Depends on hkr_pkg. Purely combinational.
module hkr_decide (
	input  hkr_pkg::event_t              ev,
	input  hkr_pkg::bind_arr_t           bindings,
	input  logic                         map_bit,
	input  logic [hkr_pkg::KEY_W-1:0]    held_key,
	output logic                         has_result,
	output hkr_pkg::result_t             res,
	output hkr_pkg::map_op_t             op
);

	logic [hkr_pkg::MOD_W-1:0]      talk_mods;
	logic                           talk_drop;
	logic                           found;
	logic [hkr_pkg::BIND_IDX_W-1:0] hit_idx;

	assign talk_mods = bindings[hkr_pkg::REG_TALK][hkr_pkg::BIND_W-1:hkr_pkg::KEY_W];
	assign talk_drop = (held_key != '0) && (ev.key != held_key) &&
		((ev.mods & talk_mods) != talk_mods);

	// first matching binding wins
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = hkr_pkg::NUM_BIND - 1; i >= 0; i--) begin
			if (bindings[i] == {ev.mods, ev.key}) begin
				found   = 1'b1;
				hit_idx = hkr_pkg::BIND_IDX_W'(i);
			end
		end
	end

	always_comb begin
		has_result = 1'b0;
		res        = '0;
		op         = '0;
		case (ev.cmd)
			hkr_pkg::CMD_CANCEL: begin
				op.clr_bit   = 1'b1;
				op.hold_drop = (held_key == ev.key);
			end
			hkr_pkg::CMD_CLEAR: begin
				op.clr_all   = 1'b1;
				op.hold_drop = 1'b1;
			end
			hkr_pkg::CMD_KEY: begin
				has_result = 1'b1;
				if (talk_drop) begin
					op.hold_drop = 1'b1;
					res.action   = hkr_pkg::ACT_TALK_REL;
					res.key      = ev.key;
				end else if (!ev.down) begin
					if (map_bit) begin
						op.clr_bit   = 1'b1;
						op.hold_drop = (ev.key == held_key);
						res.action   = (ev.key == held_key) ? hkr_pkg::ACT_TALK_REL
							: hkr_pkg::ACT_NONE;
						res.key      = ev.key;
						res.suppress = 1'b1;
					end
				end else if (ev.rpt) begin
					res.key      = ev.key;
					res.suppress = map_bit;
				end else if (found && !(hkr_pkg::needs_companion(hit_idx) && !ev.companion)) begin
					op.set_bit   = 1'b1;
					op.hold_set  = (hit_idx == hkr_pkg::REG_TALK);
					res.action   = hkr_pkg::bind_action(hit_idx);
					res.key      = ev.key;
					res.suppress = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/hkr_keymap.sv @@
// Suppressed-key bitmap and held push-to-talk key.
// Depends on hkr_pkg. Bitmap is cleared as a whole by reset or a clear command.
module hkr_keymap #(
	parameter int KEY_SPACE = hkr_pkg::KEY_SPACE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  hkr_pkg::map_op_t           op,
	input  logic [hkr_pkg::KEY_W-1:0]  key,
	output logic                       map_bit,
	output logic [hkr_pkg::KEY_W-1:0]  held_key
);

	localparam int IDX_W = $clog2(KEY_SPACE);

	logic [KEY_SPACE-1:0]      map_q;
	logic [hkr_pkg::KEY_W-1:0] held_q;
	logic [IDX_W-1:0]          idx;
	logic                      in_range;

	// keys beyond the map read as clear and are never written
	assign in_range = (32'(key) < 32'(KEY_SPACE));
	assign idx      = IDX_W'(key);
	assign map_bit  = in_range && map_q[idx];
	assign held_key = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (upd) begin
			if (op.clr_all) begin
				map_q <= '0;
			end else if (in_range && op.set_bit) begin
				map_q[idx] <= 1'b1;
			end else if (in_range && op.clr_bit) begin
				map_q[idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (upd) begin
			if (op.hold_drop) begin
				held_q <= '0;
			end else if (op.hold_set) begin
				held_q <= key;
			end
		end
	end

endmodule

@@ design/hotkey_router_with_suppression.sv @@
// Hotkey router: an event passes through the event register, then the result register.
// Throughput one event per cycle while results are taken. While a stalled result sits in the
// result register, one more event is taken into the event register; after that the input
// stalls if that event has a result. Events with no result (cancel, clear, unused) retire anyway.
// Reset clears the bitmap, the held key, the bindings and both valid flags.
module hotkey_router_with_suppression #(
	parameter int KEY_SPACE = hkr_pkg::KEY_SPACE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hkr_pkg::ADDR_W-1:0]        paddr,
	input  logic [hkr_pkg::DATA_W-1:0]        pwdata,
	output logic [hkr_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	// events
	input  logic                              event_valid,
	output logic                              event_ready,
	input  logic [1:0]                        command,
	input  logic [hkr_pkg::KEY_W-1:0]         key_code,
	input  logic                              key_press,
	input  logic                              is_repeat,
	input  logic                              mod_control,
	input  logic                              mod_shift,
	input  logic                              mod_alt,
	input  logic                              mod_system,
	input  logic                              companion_active,
	// results
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [2:0]                        action,
	output logic [hkr_pkg::KEY_W-1:0]         event_key,
	output logic                              suppress
);

	hkr_pkg::bind_arr_t             bind_q;
	logic [hkr_pkg::BIND_IDX_W-1:0] reg_idx;
	logic                           cfg_wr;

	hkr_pkg::event_t                ev_s1;
	logic                           valid_s1;
	logic                           go;
	logic                           accept;

	logic                           has_result;
	hkr_pkg::result_t               res;
	hkr_pkg::map_op_t               op;
	logic                           map_bit;
	logic [hkr_pkg::KEY_W-1:0]      held_key;

	hkr_pkg::result_t               res_s2;
	logic                           valid_s2;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[hkr_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bind_q <= '0;
		end else if (cfg_wr && (32'(reg_idx) < hkr_pkg::NUM_BIND)) begin
			bind_q[reg_idx] <= pwdata[hkr_pkg::BIND_W-1:0];
		end
	end

	always_comb begin
		if (32'(reg_idx) < hkr_pkg::NUM_BIND) begin
			prdata = hkr_pkg::DATA_W'(bind_q[reg_idx]);
		end else begin
			prdata = '0;
		end
	end

	// event register; retires when its result has somewhere to go
	assign go          = valid_s1 && (!has_result || !valid_s2 || result_ready);
	assign event_ready = !valid_s1 || go;
	assign accept      = event_valid && event_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= '{cmd: command, key: key_code, down: key_press, rpt: is_repeat,
				mods: {mod_system, mod_alt, mod_shift, mod_control},
				companion: companion_active};
		end
	end

	hkr_decide u_decide (
		.ev         (ev_s1),
		.bindings   (bind_q),
		.map_bit    (map_bit),
		.held_key   (held_key),
		.has_result (has_result),
		.res        (res),
		.op         (op)
	);

	hkr_keymap #(
		.KEY_SPACE (KEY_SPACE)
	) u_keymap (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (go),
		.op       (op),
		.key      (ev_s1.key),
		.map_bit  (map_bit),
		.held_key (held_key)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go && has_result) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign action       = res_s2.action;
	assign event_key    = res_s2.key;
	assign suppress     = res_s2.suppress;

endmodule

@@ design/hkr_checker.sv @@
// Port-level checks for the hotkey router, bound to the top level.
// Depends on hkr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hkr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [2:0]                     action,
	input logic [hkr_pkg::KEY_W-1:0]      event_key,
	input logic                           suppress
);

	`ASSERT_IMP(a_pready_high, clk, arst_n, 1'b1, pready)

	`ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(action) && $stable(event_key) && $stable(suppress))

	// a press on the talk binding is always swallowed
	`ASSERT_IMP(a_talk_press_sup, clk, arst_n, result_valid && (action == hkr_pkg::ACT_TALK_PRESS), suppress)

	// the other bound commands come only from a matched press
	`ASSERT_IMP(a_bound_sup, clk, arst_n, result_valid && (action == hkr_pkg::ACT_TOGGLE || action == hkr_pkg::ACT_TRANSLATE || action == hkr_pkg::ACT_UNDO || action == hkr_pkg::ACT_CANCEL), suppress)

endmodule

bind hotkey_router_with_suppression hkr_checker u_hkr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.action       (action),
	.event_key    (event_key),
	.suppress     (suppress)
);

@@ bench/hotkey_router_with_suppression_test.sv @@
// Self-checking bench for hotkey_router_with_suppression: directed rows, then random phases.
// Carries its own decision predictor; depends on hkr_pkg and the router RTL only.
module hotkey_router_with_suppression_test;
	import hkr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [3:0] MOD_CTRL   = 4'h1;
	localparam logic [3:0] MOD_SHIFT  = 4'h2;
	localparam logic [3:0] MOD_ALT    = 4'h4;
	localparam logic [3:0] MOD_SYS    = 4'h8;
	localparam logic [3:0] MOD_ALL    = MOD_CTRL | MOD_SHIFT | MOD_ALT | MOD_SYS;
	localparam logic [2:0] BIND_ACTION [NUM_BIND] =
		'{ACT_TALK_PRESS, ACT_TOGGLE, ACT_TRANSLATE, ACT_UNDO, ACT_CANCEL};
	localparam int SETTLE       = 4;
	localparam int LONG_HOLD    = 200;
	localparam int PHASE_EVENTS = 260;

	typedef enum bit {ROW_EVENT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		event_t                    ev;
		logic [BIND_IDX_W-1:0]     reg_idx;
		logic [BIND_W-1:0]         reg_val;
		bit                        pinned;
		result_t                   pin;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic event_valid = 1'b0;
	logic event_ready;
	logic [1:0] command = CMD_KEY;
	logic [KEY_W-1:0] key_code = '0;
	logic key_press = 1'b0;
	logic is_repeat = 1'b0;
	logic mod_control = 1'b0;
	logic mod_shift = 1'b0;
	logic mod_alt = 1'b0;
	logic mod_system = 1'b0;
	logic companion_active = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [2:0] action;
	logic [KEY_W-1:0] event_key;
	logic suppress;

	// typed expectation travelling with a directed transfer
	bit pin_on = 1'b0;
	result_t pin_res = '0;

	// predictor state
	logic [255:0] swallow_map = '0;
	logic [KEY_W-1:0] talk_key = '0;
	logic [BIND_W-1:0] binding [NUM_BIND] = '{default: '0};

	result_t pending_decisions [$];
	int fault_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	row_t directed_rows [$];

	hotkey_router_with_suppression uut (.*);

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit route_hotkey(input event_t ev, output result_t res);
		logic [MOD_W-1:0] talk_mods;
		res = '0;
		talk_mods = binding[REG_TALK][BIND_W-1:KEY_W];
		case (ev.cmd)
			CMD_CANCEL: begin
				swallow_map[ev.key] = 1'b0;
				if (talk_key == ev.key)
					talk_key = '0;
				return 1'b0;
			end
			CMD_CLEAR: begin
				swallow_map = '0;
				talk_key = '0;
				return 1'b0;
			end
			CMD_KEY: ;
			default: return 1'b0;
		endcase
		// held talk key lets go once its modifiers drop on another key
		if (talk_key != '0 && ev.key != talk_key && (ev.mods & talk_mods) != talk_mods) begin
			talk_key = '0;
			res.action = ACT_TALK_REL;
			res.key = ev.key;
			return 1'b1;
		end
		if (!ev.down) begin
			if (!swallow_map[ev.key])
				return 1'b1;
			swallow_map[ev.key] = 1'b0;
			res.key = ev.key;
			res.suppress = 1'b1;
			if (ev.key == talk_key) begin
				talk_key = '0;
				res.action = ACT_TALK_REL;
			end
			return 1'b1;
		end
		if (ev.rpt) begin
			res.key = ev.key;
			res.suppress = swallow_map[ev.key];
			return 1'b1;
		end
		for (int i = 0; i < NUM_BIND; i++) begin
			if (binding[i] == {ev.mods, ev.key}) begin
				if (i >= REG_UNDO && !ev.companion)
					return 1'b1;
				swallow_map[ev.key] = 1'b1;
				if (i == REG_TALK)
					talk_key = ev.key;
				res.action = BIND_ACTION[i];
				res.key = ev.key;
				res.suppress = 1'b1;
				return 1'b1;
			end
		end
		return 1'b1;
	endfunction

	function automatic row_t key_row(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
			input logic down, input logic rpt, input logic [MOD_W-1:0] mods,
			input logic comp);
		row_t r;
		r = '{kind: ROW_EVENT, ev: '0, reg_idx: '0, reg_val: '0, pinned: 1'b0, pin: '0};
		r.ev.cmd = cmd;
		r.ev.key = key;
		r.ev.down = down;
		r.ev.rpt = rpt;
		r.ev.mods = mods;
		r.ev.companion = comp;
		return r;
	endfunction

	function automatic row_t pin_row(input logic [KEY_W-1:0] key, input logic down,
			input logic [MOD_W-1:0] mods, input logic comp, input logic [2:0] act,
			input logic [KEY_W-1:0] k, input logic sup);
		row_t r;
		r = key_row(CMD_KEY, key, down, 1'b0, mods, comp);
		r.pinned = 1'b1;
		r.pin.action = act;
		r.pin.key = k;
		r.pin.suppress = sup;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [BIND_IDX_W-1:0] idx,
			input logic [BIND_W-1:0] val);
		row_t r;
		r = key_row(CMD_KEY, '0, 1'b0, 1'b0, '0, 1'b0);
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// mostly presses, repeats and releases of bound keys; the rest is noise
	function automatic event_t random_keystroke();
		event_t ev;
		int pick;
		int b;
		ev = '0;
		pick = $urandom_range(99);
		b = $urandom_range(NUM_BIND - 1);
		if (pick < 70) begin
			ev.cmd = CMD_KEY;
			ev.key = binding[b][KEY_W-1:0];
			ev.mods = binding[b][BIND_W-1:KEY_W];
			if ($urandom_range(9) == 0)
				ev.mods[$urandom_range(MOD_W - 1)] ^= 1'b1;
			ev.down = ($urandom_range(99) < 60);
			ev.rpt = ev.down && ($urandom_range(3) == 0);
			ev.companion = ($urandom_range(3) != 0);
		end else if (pick < 92) begin
			ev.cmd = CMD_KEY;
			ev.key = KEY_W'($urandom_range(255));
			ev.down = 1'($urandom_range(1));
			ev.rpt = 1'($urandom_range(1));
			ev.mods = MOD_W'($urandom_range(15));
			ev.companion = 1'($urandom_range(1));
		end else if (pick < 97) begin
			ev.cmd = CMD_CANCEL;
			ev.key = $urandom_range(1) ? binding[b][KEY_W-1:0] : KEY_W'($urandom_range(255));
			ev.mods = MOD_W'($urandom_range(15));
		end else if (pick < 99) begin
			ev.cmd = CMD_CLEAR;
			ev.key = KEY_W'($urandom_range(255));
		end else begin
			ev.cmd = CMD_UNUSED;
			ev.key = KEY_W'($urandom_range(255));
			ev.down = 1'($urandom_range(1));
		end
		return ev;
	endfunction

	// called on a rising edge; returns on the edge where the transfer happens
	task automatic offer(input event_t ev, input bit pinned, input result_t pin);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			event_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		event_valid <= 1'b1;
		command <= ev.cmd;
		key_code <= ev.key;
		key_press <= ev.down;
		is_repeat <= ev.rpt;
		mod_control <= ev.mods[0];
		mod_shift <= ev.mods[1];
		mod_alt <= ev.mods[2];
		mod_system <= ev.mods[3];
		companion_active <= ev.companion;
		pin_on <= pinned;
		pin_res <= pin;
		@(posedge clk);
		while (!event_ready)
			@(posedge clk);
	endtask

	// cancel and clear give no result, so allow the pipe to empty afterwards
	task automatic drain();
		event_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves psel high so back-to-back writes need no extra edge
	task automatic write_binding(input logic [BIND_IDX_W-1:0] idx,
			input logic [BIND_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		binding[idx] = val;
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		event_t seen;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.action = action;
				got.key = event_key;
				got.suppress = suppress;
				if (pending_decisions.size() == 0) begin
					$error("unexpected result: action %0d key %0d suppress %0d",
						got.action, got.key, got.suppress);
					fault_count++;
				end else begin
					want = pending_decisions.pop_front();
					if (got.action !== want.action) begin
						$error("action: expected %0d, got %0d", want.action, got.action);
						fault_count++;
					end
					if (got.key !== want.key) begin
						$error("event_key: expected %0d, got %0d", want.key, got.key);
						fault_count++;
					end
					if (got.suppress !== want.suppress) begin
						$error("suppress: expected %0d, got %0d", want.suppress,
							got.suppress);
						fault_count++;
					end
				end
			end
			if (event_valid && event_ready) begin
				seen.cmd = command;
				seen.key = key_code;
				seen.down = key_press;
				seen.rpt = is_repeat;
				seen.mods = {mod_system, mod_alt, mod_shift, mod_control};
				seen.companion = companion_active;
				if (route_hotkey(seen, want)) begin
					if (pin_on)
						want = pin_res;
					pending_decisions.push_back(want);
				end
			end
		end
	end

	initial begin
		logic [BIND_W-1:0] vals [NUM_BIND];
		// reset bindings: every binding is key 0 with no modifiers
		directed_rows.push_back(pin_row(8'h00, 1'b1, '0, 1'b0, ACT_TALK_PRESS, 8'h00, 1'b1));
		directed_rows.push_back(key_row(CMD_KEY, 8'h00, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(pin_row(8'hFF, 1'b1, MOD_ALL, 1'b1, ACT_NONE, 8'h00, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'hFF, 1'b1, 1'b1, MOD_ALL, 1'b1));
		directed_rows.push_back(key_row(CMD_UNUSED, 8'h55, 1'b1, 1'b0, MOD_ALT, 1'b0));
		directed_rows.push_back(cfg_row(REG_TALK, {MOD_CTRL, 8'h20}));
		directed_rows.push_back(cfg_row(REG_TOGGLE, {MOD_SHIFT, 8'h41}));
		directed_rows.push_back(cfg_row(REG_TRANSLATE, 12'hFFF));
		directed_rows.push_back(cfg_row(REG_UNDO, {4'h0, 8'h5A}));
		directed_rows.push_back(cfg_row(REG_CANCEL, {4'h0, 8'h1B}));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b1, 1'b0, MOD_CTRL, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b1, 1'b1, MOD_CTRL, 1'b0));
		// talk modifier dropped on another key
		directed_rows.push_back(pin_row(8'h30, 1'b1, '0, 1'b0, ACT_TALK_REL, 8'h30, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b0, 1'b0, MOD_CTRL, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h41, 1'b1, 1'b0, MOD_SHIFT, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'hFF, 1'b1, 1'b0, MOD_ALL, 1'b0));
		// undo without the companion flag passes through as the empty decision
		directed_rows.push_back(pin_row(8'h5A, 1'b1, '0, 1'b0, ACT_NONE, 8'h00, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h5A, 1'b1, 1'b0, '0, 1'b1));
		directed_rows.push_back(key_row(CMD_KEY, 8'h1B, 1'b1, 1'b0, '0, 1'b1));
		directed_rows.push_back(key_row(CMD_CANCEL, 8'h41, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(pin_row(8'h41, 1'b0, MOD_SHIFT, 1'b0, ACT_NONE, 8'h00, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b1, 1'b0, MOD_CTRL, 1'b0));
		directed_rows.push_back(key_row(CMD_CANCEL, 8'h20, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h30, 1'b1, 1'b0, '0, 1'b0));
		directed_rows.push_back(key_row(CMD_CLEAR, 8'h00, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(pin_row(8'hFF, 1'b0, MOD_ALL, 1'b0, ACT_NONE, 8'h00, 1'b0));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b1, 1'b0, MOD_CTRL, 1'b1));
		directed_rows.push_back(key_row(CMD_KEY, 8'h20, 1'b0, 1'b0, MOD_CTRL, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_CFG) begin
				drain();
				write_binding(directed_rows[n].reg_idx, directed_rows[n].reg_val);
				apb_release();
			end else begin
				offer(directed_rows[n].ev, directed_rows[n].pinned, directed_rows[n].pin);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			foreach (vals[i])
				vals[i] = BIND_W'($urandom_range(4095));
			case (ph)
				1: foreach (vals[i]) vals[i] = 12'hFFF;
				2: vals[REG_UNDO] = vals[REG_TRANSLATE];
				3: vals[REG_TALK] = '0;
				default: ;
			endcase
			foreach (vals[i])
				write_binding(BIND_IDX_W'(i), vals[i]);
			apb_release();
			case (ph)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 45; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 45; end
				3: begin gap_pct = 7; stall_pct = 7; end
				default: begin
					// long receiver hold-off while items keep coming
					gap_pct = 0;
					stall_pct = 0;
					hold_req++;
				end
			endcase
			repeat (PHASE_EVENTS) offer(random_keystroke(), 1'b0, '0);
		end

		drain();
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
